// ----- rtl/awlc_pkg.sv -----
// ----------------------------------------------------------------------------
// awlc_pkg
// Shared widths, constants and types for the ADC window level classifier.
// ----------------------------------------------------------------------------
package awlc_pkg;

	localparam int DATA_W     = 12;
	// Window length; a power of two so the mean is a plain shift of the sum.
	localparam int WINDOW     = 8;
	localparam int IDX_W      = $clog2(WINDOW);
	localparam int SUM_W      = DATA_W + IDX_W;
	localparam int CNT_W      = $clog2(WINDOW + 1);
	localparam int THR_W      = 4;
	localparam int LEVEL_W    = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	localparam logic [THR_W-1:0]  THR_RESET   = THR_W'(4);
	localparam logic [DATA_W-1:0] LIMIT_RESET = DATA_W'(1706);

	localparam logic [LEVEL_W-1:0] LEVEL_NONE = 2'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_COUNT_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT       = 1'b1;

	// Window statistics handed from the scan engine to the top level.
	typedef struct packed {
		logic               done;
		logic [LEVEL_W-1:0] level;
		logic [DATA_W-1:0]  mean;
	} awlc_stats_t;

endpackage

// ----- rtl/awlc_ram.sv -----
// ----------------------------------------------------------------------------
// awlc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module awlc_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/awlc_stats.sv -----
// ----------------------------------------------------------------------------
// awlc_stats
// Two-pass scan of the window RAM: max/min/sum, then count above midpoint.
// ----------------------------------------------------------------------------
module awlc_stats (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [awlc_pkg::THR_W-1:0] count_threshold,
	output logic                       rd_en,
	output logic [awlc_pkg::IDX_W-1:0] rd_addr,
	input  logic [awlc_pkg::DATA_W-1:0] rd_data,
	output awlc_pkg::awlc_stats_t      stats
);
	import awlc_pkg::*;

	localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
	localparam logic [IDX_W:0] CNT_END = (IDX_W + 1)'(WINDOW);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MID,
		ST_COUNT,
		ST_FIN
	} state_t;

	state_t              state_q;
	logic [IDX_W:0]      cnt_q;
	logic                dv_q;
	logic [DATA_W-1:0]   hi_q;
	logic [DATA_W-1:0]   lo_q;
	logic [SUM_W-1:0]    sum_q;
	logic [DATA_W-1:0]   mid_q;
	logic [CNT_W-1:0]    above_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [DATA_W-1:0]   mean_q;
	logic                done_q;

	logic                issue;
	logic [DATA_W:0]     hl_sum;

	assign issue   = ((state_q == ST_SCAN) || (state_q == ST_COUNT)) && (cnt_q < CNT_END);
	assign rd_en   = issue;
	assign rd_addr = cnt_q[IDX_W-1:0];
	assign hl_sum  = {1'b0, hi_q} + {1'b0, lo_q};

	assign stats.done  = done_q;
	assign stats.level = level_q;
	assign stats.mean  = mean_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			dv_q    <= 1'b0;
			hi_q    <= '0;
			lo_q    <= '1;
			sum_q   <= '0;
			mid_q   <= '0;
			above_q <= '0;
			level_q <= LEVEL_NONE;
			mean_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			dv_q   <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						hi_q    <= '0;
						lo_q    <= '1;
						sum_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (dv_q) begin
						if (rd_data > hi_q) hi_q <= rd_data;
						if (rd_data < lo_q) lo_q <= rd_data;
						sum_q <= sum_q + SUM_W'(rd_data);
					end
					// last read data lands in the cycle the counter hits the end
					if (cnt_q == CNT_END) begin
						state_q <= ST_MID;
					end
				end
				ST_MID: begin
					mid_q   <= hl_sum[DATA_W:1];
					cnt_q   <= '0;
					above_q <= '0;
					state_q <= ST_COUNT;
				end
				ST_COUNT: begin
					if (dv_q && (rd_data > mid_q)) begin
						above_q <= above_q + 1'b1;
					end
					if (cnt_q == CNT_END) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					level_q <= (CMP_W'(above_q) > CMP_W'(count_threshold)) ?
						LEVEL_HIGH : LEVEL_LOW;
					mean_q  <= sum_q[IDX_W +: DATA_W];
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/adc_window_level_classifier_core.sv -----
// ----------------------------------------------------------------------------
// adc_window_level_classifier_core
// Windowed ADC level classifier with running peak and low-limit flag.
// ----------------------------------------------------------------------------
// Every accepted sample yields one result beat. Samples go into an eight-entry
// window RAM; a sample that does not close the window has its result beat
// loaded as it is accepted, and that result carries the held level and mean.
// The sample that closes the window starts two read passes over the window
// RAM's single read port (max/min/sum, then a count above the midpoint)
// before its result beat is offered. One item is in work at a time. The peak
// and below_limit fields are always current. Configuration writes take effect
// at once and belong in idle periods.
module adc_window_level_classifier_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [awlc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [awlc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [awlc_pkg::DATA_W-1:0]     sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            window_done,
	output logic [awlc_pkg::LEVEL_W-1:0]    level,
	output logic [awlc_pkg::DATA_W-1:0]     mean,
	output logic [awlc_pkg::DATA_W-1:0]     peak,
	output logic                            below_limit
);
	import awlc_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_POST
	} state_t;

	state_t             state_q;
	logic [THR_W-1:0]   thr_q;
	logic [DATA_W-1:0]  limit_q;
	logic [IDX_W-1:0]   wr_idx_q;
	logic [DATA_W-1:0]  peak_q;
	logic               out_valid_q;
	logic               done_o_q;
	logic [LEVEL_W-1:0] level_o_q;
	logic [DATA_W-1:0]  mean_o_q;
	logic [DATA_W-1:0]  peak_o_q;
	logic               below_o_q;

	logic               out_free;
	logic               accept;
	logic               closes;
	logic               out_load;
	logic [DATA_W-1:0]  peak_nxt;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic [DATA_W-1:0]  rd_data;
	awlc_stats_t        stats;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign accept   = in_valid && in_ready;
	assign closes   = (wr_idx_q == LAST_IDX);
	assign peak_nxt = (sample > peak_q) ? sample : peak_q;
	// a new result beat is loaded this cycle
	assign out_load = (accept && !closes) || ((state_q == ST_POST) && out_free);

	assign out_valid   = out_valid_q;
	assign window_done = done_o_q;
	assign level       = level_o_q;
	assign mean        = mean_o_q;
	assign peak        = peak_o_q;
	assign below_limit = below_o_q;

	awlc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (WINDOW)
	) u_window_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (wr_idx_q),
		.wdata (sample),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	awlc_stats u_stats (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (accept && closes),
		.count_threshold (thr_q),
		.rd_en           (rd_en),
		.rd_addr         (rd_addr),
		.rd_data         (rd_data),
		.stats           (stats)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= THR_RESET;
			limit_q     <= LIMIT_RESET;
			wr_idx_q    <= '0;
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_COUNT_THRESHOLD: thr_q   <= cfg_data[THR_W-1:0];
					CFG_LOW_LIMIT:       limit_q <= cfg_data[DATA_W-1:0];
					default: ;
				endcase
			end

			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						peak_q <= peak_nxt;
						if (closes) begin
							wr_idx_q <= '0;
							state_q  <= ST_BUSY;
						end else begin
							wr_idx_q    <= wr_idx_q + 1'b1;
							out_valid_q <= 1'b1;
							done_o_q    <= 1'b0;
							level_o_q   <= stats.level;
							mean_o_q    <= stats.mean;
							peak_o_q    <= peak_nxt;
							below_o_q   <= (peak_nxt <= limit_q);
						end
					end
				end
				ST_BUSY: begin
					if (stats.done) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					// wait for the output beat to drain before loading
					if (out_free) begin
						out_valid_q <= 1'b1;
						done_o_q    <= 1'b1;
						level_o_q   <= stats.level;
						mean_o_q    <= stats.mean;
						peak_o_q    <= peak_q;
						below_o_q   <= (peak_q <= limit_q);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- tb/sv/awlc_reading_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// awlc_reading_checker
// Watches the config port and both sample/result channels of the window level
// classifier, keeps its own copy of the window, peak and registers, predicts
// one reading per accepted sample and compares every result beat with it.
// ----------------------------------------------------------------------------
module awlc_reading_checker
	import awlc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [DATA_W-1:0]     sample,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic                  window_done,
	input  logic [LEVEL_W-1:0]    level,
	input  logic [DATA_W-1:0]     mean,
	input  logic [DATA_W-1:0]     peak,
	input  logic                  below_limit,
	output int                    outstanding,
	output int                    mismatches
);

	typedef struct packed {
		logic               done;
		logic [LEVEL_W-1:0] level;
		logic [DATA_W-1:0]  mean;
		logic [DATA_W-1:0]  peak;
		logic               below;
	} reading_t;

	reading_t          pending_readings[$];

	logic [DATA_W-1:0] win_q [WINDOW];
	logic [IDX_W-1:0]  wr_idx;
	logic [LEVEL_W-1:0] level_q;
	logic [DATA_W-1:0] mean_q;
	logic [DATA_W-1:0] peak_q;
	logic [THR_W-1:0]  thr_q;
	logic [DATA_W-1:0] limit_q;

	// Advances the model by one sample and returns the reading it produces.
	function automatic reading_t next_reading(input logic [DATA_W-1:0] s);
		reading_t        r;
		logic [DATA_W-1:0] hi;
		logic [DATA_W-1:0] lo;
		logic [SUM_W-1:0]  sum;
		logic [DATA_W:0]   mid;
		int                above;
		r.done = 1'b0;
		if (s > peak_q)
			peak_q = s;
		win_q[wr_idx] = s;
		if (wr_idx == IDX_W'(WINDOW - 1)) begin
			hi = '0;
			lo = '1;
			sum = '0;
			foreach (win_q[i]) begin
				if (win_q[i] > hi) hi = win_q[i];
				if (win_q[i] < lo) lo = win_q[i];
				sum += SUM_W'(win_q[i]);
			end
			mid = ({1'b0, hi} + {1'b0, lo}) >> 1;
			above = 0;
			foreach (win_q[i])
				if ({1'b0, win_q[i]} > mid) above++;
			level_q = (above > int'(thr_q)) ? LEVEL_HIGH : LEVEL_LOW;
			mean_q = DATA_W'(sum / WINDOW);
			r.done = 1'b1;
		end
		wr_idx = wr_idx + 1'b1;
		r.level = level_q;
		r.mean = mean_q;
		r.peak = peak_q;
		r.below = (peak_q <= limit_q);
		return r;
	endfunction

	function automatic int field_bad(input string name, input int exp_v, input int act_v);
		if (exp_v == act_v)
			return 0;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t exp_r;
		int       bad;
		if (!arst_n) begin
			pending_readings.delete();
			wr_idx = '0;
			level_q = LEVEL_NONE;
			mean_q = '0;
			peak_q = '0;
			thr_q = THR_RESET;
			limit_q = LIMIT_RESET;
			outstanding <= 0;
			mismatches <= 0;
		end else begin
			bad = 0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_COUNT_THRESHOLD: thr_q = cfg_data[THR_W-1:0];
					CFG_LOW_LIMIT:       limit_q = cfg_data[DATA_W-1:0];
					default: ;
				endcase
			end
			// result beat is checked before this edge's sample is modeled
			if (out_valid && out_ready) begin
				if (pending_readings.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual %0d/%0d/%0d/%0d/%0d",
						$time, window_done, level, mean, peak, below_limit);
					bad++;
				end else begin
					exp_r = pending_readings.pop_front();
					bad += field_bad("window_done", exp_r.done, window_done);
					bad += field_bad("level", exp_r.level, level);
					bad += field_bad("mean", exp_r.mean, mean);
					bad += field_bad("peak", exp_r.peak, peak);
					bad += field_bad("below_limit", exp_r.below, below_limit);
				end
			end
			if (in_valid && in_ready)
				pending_readings.push_back(next_reading(sample));
			outstanding <= pending_readings.size();
			mismatches <= mismatches + bad;
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the ADC window level classifier: directed windows covering
// the sample extremes, a flat window and the low-limit edge, then random
// traffic in bursts under several register settings with a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
	import awlc_pkg::*;

	localparam int IDLE_LIMIT       = 2000;
	localparam int RANDOM_PER_PHASE = 216;
	localparam int PHASES           = 6;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_COUNT_THRESHOLD;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [DATA_W-1:0]     sample = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  window_done;
	logic [LEVEL_W-1:0]    level;
	logic [DATA_W-1:0]     mean;
	logic [DATA_W-1:0]     peak;
	logic                  below_limit;

	int outstanding;
	int mismatches;
	int idle_cycles = 0;
	int ready_mode = 0;
	int mode_left = 0;
	int hold_left = 0;

	adc_window_level_classifier_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.window_done(window_done),
		.level      (level),
		.mean       (mean),
		.peak       (peak),
		.below_limit(below_limit)
	);

	awlc_reading_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.window_done(window_done),
		.level      (level),
		.mean       (mean),
		.peak       (peak),
		.below_limit(below_limit),
		.outstanding(outstanding),
		.mismatches (mismatches)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: switches between free-running, random, mostly-stalled and long runs
	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode <= $urandom_range(0, 3);
			mode_left <= $urandom_range(20, 120);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 7) == 0);
			default: begin
				if (hold_left == 0) begin
					out_ready <= ~out_ready;
					hold_left <= $urandom_range(0, 25);
				end else begin
					hold_left <= hold_left - 1;
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("adc_window_level_classifier_core regression: fail");
			$finish;
		end
	end

	task automatic push_sample(input logic [DATA_W-1:0] v);
		in_valid <= 1'b1;
		sample <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// waits until every result beat is back, leaving the block idle
	task automatic drain_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_config(input logic [THR_W-1:0] thr, input logic [DATA_W-1:0] lim);
		cfg_we <= 1'b1;
		cfg_index <= CFG_COUNT_THRESHOLD;
		cfg_data <= CFG_DATA_W'(thr);
		@(posedge clk);
		cfg_index <= CFG_LOW_LIMIT;
		cfg_data <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_traffic(input int n);
		int                sent;
		int                burst;
		int                gap;
		int                k;
		int                spread;
		int                tmp;
		logic [DATA_W-1:0] base;
		logic [DATA_W-1:0] v;
		sent = 0;
		base = '0;
		while (sent < n) begin
			burst = $urandom_range(1, 24);
			for (k = 0; k < burst && sent < n; k++) begin
				if (sent % WINDOW == 0)
					base = DATA_W'($urandom_range(0, 4095));
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: v = DATA_W'($urandom_range(0, 4095));
					5: v = $urandom_range(0, 1) ? '1 : '0;
					default: begin
						// tight cluster so the midpoint count lands anywhere
						spread = 1 << $urandom_range(0, 6);
						tmp = int'(base) + $urandom_range(0, spread);
						v = (tmp > 4095) ? '1 : DATA_W'(tmp);
					end
				endcase
				push_sample(v);
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		logic [DATA_W-1:0] directed [24];
		logic [THR_W-1:0]  thr_set [PHASES];
		logic [DATA_W-1:0] lim_set [PHASES];
		// window that crosses the default low limit exactly
		directed = '{12'd0, 12'd1706, 12'd1707, 12'd100, 12'd200, 12'd300, 12'd400, 12'd500,
			// flat window at full scale: nothing above the midpoint
			12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
			// five of eight above midpoint, exceeds the default threshold
			12'hFFF, 12'd0, 12'd0, 12'd0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF};
		thr_set = '{4'd0, 4'd8, 4'd15, 4'd1, 4'($urandom_range(0, 15)), THR_RESET};
		lim_set = '{12'd0, 12'hFFF, 12'd2048, 12'($urandom_range(0, 4095)),
			12'($urandom_range(0, 4095)), LIMIT_RESET};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			push_sample(directed[i]);
		drain_idle();
		for (int p = 0; p < PHASES; p++) begin
			write_config(thr_set[p], lim_set[p]);
			random_traffic(RANDOM_PER_PHASE);
			drain_idle();
		end
		repeat (30) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("adc_window_level_classifier_core regression: pass");
		else
			$display("adc_window_level_classifier_core regression: fail");
		$finish;
	end

endmodule
